// File: rtl/core/slt_pkg.sv
// ----------------------------------------------------------------------------
// slt_pkg
// Request codes and fixed field widths shared by the sorted list table.
// ----------------------------------------------------------------------------
package slt_pkg;

  localparam int REQ_W   = 2;
  localparam int VALUE_W = 64;
  localparam int POS_W   = 7;
  localparam int CNT_W   = 7;
  localparam int CMP_W   = 7;
  localparam int MOV_W   = 6;

  typedef logic [REQ_W-1:0] req_t;

  localparam req_t REQ_INSERT = 2'd0;
  localparam req_t REQ_SEARCH = 2'd1;
  localparam req_t REQ_DELETE = 2'd2;
  localparam req_t REQ_CLEAR  = 2'd3;

endpackage

// File: rtl/core/sorted_list_table.sv
// ----------------------------------------------------------------------------
// sorted_list_table
// Table of signed 64-bit values kept in descending order in one RAM.
// ----------------------------------------------------------------------------
// One request at a time: start is taken while busy is low, and the result
// shows on the out_ ports for one cycle with out_valid high; it cannot be held
// off. Clear and an insert into a full table are answered straight from idle
// and leave busy low. Otherwise the request scans the RAM from the front,
// one read and one compare state per entry, and an insert or delete then
// moves entries one place, one read and one write state per moved entry,
// all through the single RAM read port. The entry RAM has no reset; only
// entries below the stored count are ever compared or moved.
module sorted_list_table
  import slt_pkg::*;
#(
  parameter int CAPACITY = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [REQ_W-1:0]   in_req_type,
  input  logic signed [VALUE_W-1:0] in_value,
  output logic               out_valid,
  output logic               out_ok,
  output logic [POS_W-1:0]   out_position,
  output logic [CNT_W-1:0]   out_stored_count,
  output logic [CMP_W-1:0]   out_compare_count,
  output logic [MOV_W-1:0]   out_move_count
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SCAN = 3'd1;
  localparam logic [2:0] S_CMP  = 3'd2;
  localparam logic [2:0] S_ISH  = 3'd3;
  localparam logic [2:0] S_IWR  = 3'd4;
  localparam logic [2:0] S_DSH  = 3'd5;
  localparam logic [2:0] S_DWR  = 3'd6;

  logic [2:0]   state_r, state_nxt;
  req_t         req_r, req_nxt;
  logic signed [VALUE_W-1:0] val_r, val_nxt;
  logic [CW-1:0] idx_r, idx_nxt;
  logic [CW-1:0] held_r, held_nxt;
  logic [CW-1:0] pos_r, pos_nxt;
  logic [CW-1:0] cmp_r, cmp_nxt;
  logic [CW-1:0] mov_r, mov_nxt;

  logic               out_valid_r;
  logic               out_ok_r;
  logic [POS_W-1:0]   out_position_r;
  logic [CNT_W-1:0]   out_stored_count_r;
  logic [CMP_W-1:0]   out_compare_count_r;
  logic [MOV_W-1:0]   out_move_count_r;

  // result launch
  logic          emit;
  logic          e_ok;
  logic [CW-1:0] e_pos, e_held, e_cmp, e_mov;

  logic                 ram_we;
  logic [AW-1:0]        ram_waddr, ram_raddr;
  logic [VALUE_W-1:0]   ram_wdata, ram_rdata;

  slt_ram #(
    .WIDTH (VALUE_W),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  logic [CW-1:0] idx_dec, idx_inc, cmp_inc;
  assign idx_dec = idx_r - CW'(1);
  assign idx_inc = idx_r + CW'(1);
  assign cmp_inc = cmp_r + CW'(1);

  always_comb begin
    state_nxt = state_r;
    req_nxt   = req_r;
    val_nxt   = val_r;
    idx_nxt   = idx_r;
    held_nxt  = held_r;
    pos_nxt   = pos_r;
    cmp_nxt   = cmp_r;
    mov_nxt   = mov_r;
    emit      = 1'b0;
    e_ok      = 1'b0;
    e_pos     = '0;
    e_held    = held_r;
    e_cmp     = '0;
    e_mov     = '0;
    ram_we    = 1'b0;
    ram_waddr = idx_r[AW-1:0];
    ram_wdata = ram_rdata;
    ram_raddr = idx_r[AW-1:0];

    case (state_r)
      S_IDLE: begin
        if (start) begin
          req_nxt = in_req_type;
          val_nxt = in_value;
          idx_nxt = '0;
          pos_nxt = '0;
          cmp_nxt = '0;
          mov_nxt = '0;
          if (in_req_type == REQ_CLEAR) begin
            held_nxt = '0;
            emit     = 1'b1;
            e_held   = '0;
          end else if (in_req_type == REQ_INSERT && held_r == CAP_C) begin
            emit = 1'b1;
          end else begin
            state_nxt = S_SCAN;
          end
        end
      end

      S_SCAN: begin
        if (idx_r == held_r) begin
          if (req_r == REQ_INSERT) begin
            // ran off the end: append after the last entry
            pos_nxt   = held_r;
            idx_nxt   = held_r;
            state_nxt = S_ISH;
          end else begin
            emit      = 1'b1;
            e_cmp     = cmp_r;
            state_nxt = S_IDLE;
          end
        end else begin
          state_nxt = S_CMP;
        end
      end

      S_CMP: begin
        cmp_nxt = cmp_inc;
        if (req_r == REQ_INSERT) begin
          if (val_r > $signed(ram_rdata)) begin
            pos_nxt   = idx_r;
            idx_nxt   = held_r;
            state_nxt = S_ISH;
          end else begin
            idx_nxt   = idx_inc;
            state_nxt = S_SCAN;
          end
        end else if (val_r == $signed(ram_rdata)) begin
          pos_nxt = idx_r;
          if (req_r == REQ_SEARCH) begin
            emit      = 1'b1;
            e_ok      = 1'b1;
            e_pos     = idx_r;
            e_cmp     = cmp_inc;
            state_nxt = S_IDLE;
          end else begin
            state_nxt = S_DSH;
          end
        end else begin
          idx_nxt   = idx_inc;
          state_nxt = S_SCAN;
        end
      end

      // insert: move entries up from the end, then place the value
      S_ISH: begin
        if (idx_r == pos_r) begin
          ram_we    = 1'b1;
          ram_wdata = val_r;
          held_nxt  = held_r + CW'(1);
          emit      = 1'b1;
          e_ok      = 1'b1;
          e_pos     = pos_r;
          e_held    = held_r + CW'(1);
          e_cmp     = cmp_r;
          e_mov     = mov_r;
          state_nxt = S_IDLE;
        end else begin
          ram_raddr = idx_dec[AW-1:0];
          state_nxt = S_IWR;
        end
      end

      S_IWR: begin
        ram_we    = 1'b1;
        idx_nxt   = idx_dec;
        mov_nxt   = mov_r + CW'(1);
        state_nxt = S_ISH;
      end

      // delete: pull later entries down over the gap
      S_DSH: begin
        if (idx_inc == held_r) begin
          held_nxt  = idx_r;
          emit      = 1'b1;
          e_ok      = 1'b1;
          e_pos     = pos_r;
          e_held    = idx_r;
          e_cmp     = cmp_r;
          e_mov     = mov_r;
          state_nxt = S_IDLE;
        end else begin
          ram_raddr = idx_inc[AW-1:0];
          state_nxt = S_DWR;
        end
      end

      S_DWR: begin
        ram_we    = 1'b1;
        idx_nxt   = idx_inc;
        mov_nxt   = mov_r + CW'(1);
        state_nxt = S_DSH;
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      held_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      held_r      <= held_nxt;
      out_valid_r <= emit;
    end
  end

  always_ff @(posedge clk) begin
    req_r <= req_nxt;
    val_r <= val_nxt;
    idx_r <= idx_nxt;
    pos_r <= pos_nxt;
    cmp_r <= cmp_nxt;
    mov_r <= mov_nxt;
    if (emit) begin
      out_ok_r            <= e_ok;
      out_position_r      <= POS_W'(e_pos);
      out_stored_count_r  <= CNT_W'(e_held);
      out_compare_count_r <= CMP_W'(e_cmp);
      out_move_count_r    <= MOV_W'(e_mov);
    end
  end

  assign busy              = (state_r != S_IDLE);
  assign out_valid         = out_valid_r;
  assign out_ok            = out_ok_r;
  assign out_position      = out_position_r;
  assign out_stored_count  = out_stored_count_r;
  assign out_compare_count = out_compare_count_r;
  assign out_move_count    = out_move_count_r;

  a_held_bound: assert property (@(posedge clk) disable iff (!rst_n)
    held_r <= CAP_C)
    else $error("stored count above capacity");

  a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> state_r == S_IDLE)
    else $error("result launched while a request is still running");

  a_clear_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_req_type == REQ_CLEAR) |=>
      (out_valid && !out_ok && out_stored_count == '0))
    else $error("clear did not finish in one cycle");

  a_write_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (state_r == S_ISH || state_r == S_IWR || state_r == S_DWR))
    else $error("RAM write outside a move step");

endmodule

// File: rtl/core/slt_ram.sv
// ----------------------------------------------------------------------------
// slt_ram
// Generic single-clock RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module slt_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// File: tb/tb_sorted_list_table.sv
// ----------------------------------------------------------------------------
// tb_sorted_list_table
// Self-checking bench: drives insert/search/delete/clear requests through the
// start/busy port, keeps a shadow of the descending table to predict each
// result and compares every out_valid strobe field by field.
// ----------------------------------------------------------------------------
module tb_sorted_list_table;
  import slt_pkg::*;

  localparam int CAPACITY = 64;
  localparam int NUM_RANDOM = 1700;
  localparam logic signed [VALUE_W-1:0] VMAX = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [VALUE_W-1:0] VMIN = 64'sh8000_0000_0000_0000;

  typedef struct packed {
    logic             ok;
    logic [POS_W-1:0] position;
    logic [CNT_W-1:0] stored_count;
    logic [CMP_W-1:0] compare_count;
    logic [MOV_W-1:0] move_count;
  } table_result_t;

  class table_scoreboard;
    logic signed [VALUE_W-1:0] vals[CAPACITY];
    int held;
    int fail_count;
    table_result_t pending_results[$];

    function new();
      held = 0;
      fail_count = 0;
    endfunction

    // shadow of the block: updates the table and returns the result it owes
    function table_result_t apply_request(req_t kind, logic signed [VALUE_W-1:0] v);
      table_result_t r;
      int i;
      int j;
      int cmp;
      int mov;
      bit stop;
      r = '0;
      cmp = 0;
      mov = 0;
      case (kind)
        REQ_INSERT: begin
          if (held < CAPACITY) begin
            i = 0;
            stop = 1'b0;
            // skip every entry equal to or larger than v
            while (i < held && !stop) begin
              cmp++;
              if (v > vals[i]) stop = 1'b1;
              else i++;
            end
            for (j = held; j > i; j--) begin
              vals[j] = vals[j-1];
              mov++;
            end
            vals[i] = v;
            held++;
            r.ok = 1'b1;
            r.position = i[POS_W-1:0];
          end
        end
        REQ_SEARCH, REQ_DELETE: begin
          stop = 1'b0;
          i = 0;
          while (i < held && !stop) begin
            cmp++;
            if (vals[i] == v) stop = 1'b1;
            else i++;
          end
          if (stop) begin
            r.ok = 1'b1;
            r.position = i[POS_W-1:0];
            if (kind == REQ_DELETE) begin
              for (j = i; j + 1 < held; j++) begin
                vals[j] = vals[j+1];
                mov++;
              end
              held--;
            end
          end
        end
        default: held = 0;
      endcase
      r.stored_count  = held[CNT_W-1:0];
      r.compare_count = cmp[CMP_W-1:0];
      r.move_count    = mov[MOV_W-1:0];
      return r;
    endfunction

    function void note_request(req_t kind, logic signed [VALUE_W-1:0] v);
      pending_results.push_back(apply_request(kind, v));
    endfunction

    function void check_result(table_result_t got);
      table_result_t want;
      if (pending_results.size() == 0) begin
        fail_count++;
        if (fail_count <= 10)
          $display("unexpected result: ok=%0d pos=%0d cnt=%0d cmp=%0d mov=%0d",
                   got.ok, got.position, got.stored_count, got.compare_count,
                   got.move_count);
        return;
      end
      want = pending_results.pop_front();
      if (got.ok !== want.ok || got.position !== want.position ||
          got.stored_count !== want.stored_count ||
          got.compare_count !== want.compare_count ||
          got.move_count !== want.move_count) begin
        fail_count++;
        if (fail_count <= 10)
          $display("mismatch: exp ok=%0d pos=%0d cnt=%0d cmp=%0d mov=%0d, got ok=%0d pos=%0d cnt=%0d cmp=%0d mov=%0d",
                   want.ok, want.position, want.stored_count, want.compare_count,
                   want.move_count, got.ok, got.position, got.stored_count,
                   got.compare_count, got.move_count);
      end
    endfunction

    function int pending();
      return pending_results.size();
    endfunction

    function logic signed [VALUE_W-1:0] pick_stored();
      return vals[$urandom_range(0, held - 1)];
    endfunction
  endclass

  logic                      clk;
  logic                      rst_n;
  logic                      start;
  logic                      busy;
  logic [REQ_W-1:0]          in_req_type;
  logic signed [VALUE_W-1:0] in_value;
  logic                      out_valid;
  logic                      out_ok;
  logic [POS_W-1:0]          out_position;
  logic [CNT_W-1:0]          out_stored_count;
  logic [CMP_W-1:0]          out_compare_count;
  logic [MOV_W-1:0]          out_move_count;

  table_scoreboard sb = new();
  bit allow_idle;

  sorted_list_table #(.CAPACITY(CAPACITY)) dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_req_type      (in_req_type),
    .in_value         (in_value),
    .out_valid        (out_valid),
    .out_ok           (out_ok),
    .out_position     (out_position),
    .out_stored_count (out_stored_count),
    .out_compare_count(out_compare_count),
    .out_move_count   (out_move_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // note first: a request answered straight from idle may report at the edge the next is taken
  always @(posedge clk) begin
    if (rst_n) begin
      if (start && !busy) sb.note_request(req_t'(in_req_type), in_value);
      if (out_valid)
        sb.check_result({out_ok, out_position, out_stored_count,
                         out_compare_count, out_move_count});
    end
  end

  task automatic send_request(req_t kind, logic signed [VALUE_W-1:0] v);
    int gap;
    start       <= 1'b1;
    in_req_type <= kind;
    in_value    <= v;
    @(posedge clk);
    while (busy) @(posedge clk);
    if (allow_idle && $urandom_range(0, 2) == 0) begin
      // mostly short gaps, now and then one that outlasts a long request
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 2*CAPACITY + 12)
                                        : $urandom_range(1, 3);
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  function automatic logic signed [VALUE_W-1:0] random_value(req_t kind);
    int r;
    r = $urandom_range(0, 99);
    if (sb.held > 0 && r < ((kind == REQ_INSERT) ? 25 : 60)) return sb.pick_stored();
    if (r < 75) begin
      case ($urandom_range(0, 8))
        0: return VMAX;
        1: return VMIN;
        2: return VMAX - 1;
        3: return VMIN + 1;
        default: return $signed(64'($urandom_range(0, 4))) - 2;
      endcase
    end
    return {$urandom(), $urandom()};
  endfunction

  initial begin
    int r;
    bit filling;
    req_t kind;
    rst_n       <= 1'b0;
    start       <= 1'b0;
    in_req_type <= REQ_CLEAR;
    in_value    <= '0;
    allow_idle  = 1'b1;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // directed: empty table, extremes, equal values, hits and misses, clear
    send_request(REQ_SEARCH, 64'sd0);
    send_request(REQ_DELETE, VMAX);
    send_request(REQ_INSERT, 64'sd0);
    send_request(REQ_INSERT, VMAX);
    send_request(REQ_INSERT, VMIN);
    send_request(REQ_INSERT, -64'sd1);
    send_request(REQ_INSERT, 64'sd0);
    send_request(REQ_INSERT, 64'sd5);
    send_request(REQ_INSERT, VMIN);
    send_request(REQ_SEARCH, 64'sd0);
    send_request(REQ_SEARCH, VMIN);
    send_request(REQ_SEARCH, 64'sd7);
    send_request(REQ_DELETE, VMIN);
    send_request(REQ_DELETE, VMAX);
    send_request(REQ_DELETE, 64'sd0);
    send_request(REQ_DELETE, 64'sd3);
    send_request(REQ_SEARCH, VMAX);
    send_request(REQ_CLEAR, VMAX);
    send_request(REQ_SEARCH, 64'sd0);
    send_request(REQ_CLEAR, 64'sd0);
    send_request(REQ_INSERT, 64'sd1);
    send_request(REQ_DELETE, 64'sd1);

    // random: fill toward full, then drain, repeated
    filling = 1'b1;
    for (int n = 0; n < NUM_RANDOM; n++) begin
      allow_idle = !(n >= 700 && n < 1000);
      if (filling && sb.held == CAPACITY && $urandom_range(0, 3) == 0) filling = 1'b0;
      else if (!filling && sb.held == 0) filling = 1'b1;
      r = $urandom_range(0, 199);
      if (filling)
        kind = (r < 150) ? REQ_INSERT : (r < 170) ? REQ_SEARCH :
               (r < 199) ? REQ_DELETE : REQ_CLEAR;
      else
        kind = (r < 30) ? REQ_INSERT : (r < 70) ? REQ_SEARCH :
               (r < 194) ? REQ_DELETE : REQ_CLEAR;
      send_request(kind, random_value(kind));
    end
    start <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (2*CAPACITY + 10) @(posedge clk);
    if (sb.fail_count == 0 && sb.pending() == 0)
      $display("tb_sorted_list_table OK");
    else
      $display("tb_sorted_list_table NOT OK");
    $finish;
  end

  initial begin
    #15_000_000;
    $display("tb_sorted_list_table NOT OK");
    $finish;
  end

endmodule
